>>> rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// Generation step package
// Shared command codes, datapath operations and controller/datapath links.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam int LGS_GRID_COLS = 64;
	localparam int LGS_GRID_ROWS = 64;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_READ    = 2'd2,
		CMD_ADVANCE = 2'd3
	} lgs_cmd_code_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_CLR_STEP,
		OP_RD_CELL,
		OP_WR_CELL,
		OP_GEN_START,
		OP_GEN_LD1,
		OP_GEN_LD2,
		OP_GEN_RUN,
		OP_GEN_END,
		OP_RESULT
	} lgs_op_t;

	typedef struct packed {
		lgs_op_t op;
	} lgs_ctl_t;

	typedef struct packed {
		logic clr_last;
		logic gen_last;
	} lgs_sts_t;

endpackage

>>> rtl/lgs_datapath.sv
// ----------------------------------------------------------------------------
// Generation step datapath
// Row-wide grid memory holding both buffers, the three-row neighbourhood
// window, the cell rule and the result registers.
// ----------------------------------------------------------------------------
module lgs_datapath import lgs_pkg::*; #(
	parameter int GRID_COLS = LGS_GRID_COLS,
	parameter int GRID_ROWS = LGS_GRID_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lgs_ctl_t   ctl,
	output lgs_sts_t   sts,
	input  logic [1:0] cmd,
	input  logic [5:0] cell_col,
	input  logic [5:0] cell_row,
	input  logic       cell_value,
	output logic       done,
	output logic       cell_alive,
	output logic       stable
);

	localparam int CW = $clog2(GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int AW = RW + 1;
	localparam int MEM_DEPTH = 2 ** AW;
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	logic [GRID_COLS-1:0] grid_mem [MEM_DEPTH];

	lgs_cmd_code_t        cmd_q;
	logic [5:0]           col_q;
	logic [5:0]           row_q;
	logic                 val_q;
	logic                 sel_q;
	logic                 stable_q;
	logic                 same_q;
	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        gc_q;
	logic [RW-1:0]        gr_q;
	logic [GRID_COLS-1:0] up_q;
	logic [GRID_COLS-1:0] mid_q;
	logic [GRID_COLS-1:0] dn_q;
	logic [GRID_COLS-1:0] nr_q;
	logic [GRID_COLS-1:0] rd_q;
	logic                 done_q;
	logic                 alive_q;
	logic                 stab_res_q;

	logic                 in_grid;
	logic [CW-1:0]        col_idx;
	logic [RW-1:0]        row_idx;
	logic                 first_col;
	logic                 last_col;
	logic                 last_row;
	logic                 ahead_ok;
	logic [3:0]           n_w;
	logic                 nxt_w;
	logic [GRID_COLS-1:0] nr_w;
	logic [GRID_COLS-1:0] wrow;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [GRID_COLS-1:0] wdata;
	logic                 re;
	logic [AW-1:0]        raddr;

	function automatic logic [GRID_COLS-1:0] rot(input logic [GRID_COLS-1:0] x);
		return {x[0], x[GRID_COLS-1:1]};
	endfunction

	function automatic logic [3:0] b4(input logic b);
		return {3'b000, b};
	endfunction

	assign in_grid   = (32'(col_q) < 32'(GRID_COLS)) && (32'(row_q) < 32'(GRID_ROWS));
	assign col_idx   = CW'(col_q);
	assign row_idx   = RW'(row_q);
	assign first_col = (gc_q == '0);
	assign last_col  = (gc_q == CW'(GRID_COLS - 1));
	assign last_row  = (gr_q == RW'(GRID_ROWS - 1));
	assign ahead_ok  = (32'(gr_q) + 32'd2) < 32'(GRID_ROWS);

	// Each window row is rotated so that bit 0 is the column being visited.
	assign n_w = b4(up_q[GRID_COLS-1] & !first_col) + b4(up_q[0]) + b4(up_q[1] & !last_col)
		+ b4(mid_q[GRID_COLS-1] & !first_col) + b4(mid_q[1] & !last_col)
		+ b4(dn_q[GRID_COLS-1] & !first_col) + b4(dn_q[0]) + b4(dn_q[1] & !last_col);
	assign nxt_w = (n_w == BIRTH_COUNT) || (mid_q[0] && (n_w == SURVIVE_COUNT));
	assign nr_w  = {nxt_w, nr_q[GRID_COLS-1:1]};

	always_comb begin
		wrow = rd_q;
		wrow[col_idx] = val_q;
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		case (ctl.op)
			OP_CLR_STEP: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			OP_RD_CELL: begin
				re    = 1'b1;
				raddr = {sel_q, row_idx};
			end
			OP_WR_CELL: begin
				we    = in_grid;
				waddr = {sel_q, row_idx};
				wdata = wrow;
			end
			OP_GEN_START: begin
				re    = 1'b1;
				raddr = {sel_q, RW'(0)};
			end
			OP_GEN_LD1: begin
				re    = 1'b1;
				raddr = {sel_q, RW'(1)};
			end
			OP_GEN_RUN: begin
				re    = first_col && ahead_ok;
				raddr = {sel_q, RW'(gr_q + RW'(2))};
				we    = last_col;
				waddr = {~sel_q, gr_q};
				wdata = nr_w;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			grid_mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= grid_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q    <= 1'b0;
			stable_q <= 1'b0;
			clr_q    <= '0;
			gc_q     <= '0;
			gr_q     <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (ctl.op == OP_RESULT);
			case (ctl.op)
				OP_LATCH: clr_q <= '0;
				OP_CLR_STEP: clr_q <= clr_q + 1'b1;
				OP_GEN_START: begin
					gc_q <= '0;
					gr_q <= '0;
				end
				OP_GEN_RUN: begin
					if (last_col) begin
						gc_q <= '0;
						gr_q <= gr_q + 1'b1;
					end else begin
						gc_q <= gc_q + 1'b1;
					end
				end
				OP_GEN_END: begin
					sel_q    <= ~sel_q;
					stable_q <= same_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LATCH: begin
				cmd_q <= lgs_cmd_code_t'(cmd);
				col_q <= cell_col;
				row_q <= cell_row;
				val_q <= cell_value;
			end
			OP_GEN_START: begin
				same_q <= 1'b1;
				up_q   <= '0;
			end
			OP_GEN_LD1: mid_q <= rd_q;
			OP_GEN_LD2: dn_q <= rd_q;
			OP_GEN_RUN: begin
				same_q <= same_q & (nxt_w == mid_q[0]);
				nr_q   <= nr_w;
				if (last_col) begin
					up_q  <= rot(mid_q);
					mid_q <= rot(dn_q);
					dn_q  <= ahead_ok ? rd_q : '0;
				end else begin
					up_q  <= rot(up_q);
					mid_q <= rot(mid_q);
					dn_q  <= rot(dn_q);
				end
			end
			OP_RESULT: begin
				alive_q    <= (cmd_q == CMD_READ) && in_grid && rd_q[col_idx];
				stab_res_q <= stable_q;
			end
			default: begin
			end
		endcase
	end

	assign sts.clr_last = &clr_q;
	assign sts.gen_last = last_col && last_row;
	assign done       = done_q;
	assign cell_alive = alive_q;
	assign stable     = stab_res_q;

endmodule

>>> rtl/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// Generation step controller
// Sequences clearing, cell access and generation sweeps over the datapath.
// ----------------------------------------------------------------------------
module lgs_ctrl import lgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	output logic       busy,
	output lgs_ctl_t   ctl,
	input  lgs_sts_t   sts
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLR,
		S_RDR,
		S_RDW,
		S_WR,
		S_GEN0,
		S_GEN1,
		S_GEN2,
		S_RUN,
		S_GEND,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_comb begin
		state_n = state_q;
		ctl.op  = OP_NOP;
		unique case (state_q)
			S_INIT: begin
				ctl.op = OP_CLR_STEP;
				if (sts.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					ctl.op = OP_LATCH;
					unique case (lgs_cmd_code_t'(cmd))
						CMD_CLEAR:   state_n = S_CLR;
						CMD_WRITE:   state_n = S_RDW;
						CMD_READ:    state_n = S_RDR;
						CMD_ADVANCE: state_n = S_GEN0;
					endcase
				end
			end
			S_CLR: begin
				ctl.op = OP_CLR_STEP;
				if (sts.clr_last) begin
					state_n = S_RESP;
				end
			end
			S_RDR: begin
				ctl.op  = OP_RD_CELL;
				state_n = S_RESP;
			end
			S_RDW: begin
				ctl.op  = OP_RD_CELL;
				state_n = S_WR;
			end
			S_WR: begin
				ctl.op  = OP_WR_CELL;
				state_n = S_RESP;
			end
			S_GEN0: begin
				ctl.op  = OP_GEN_START;
				state_n = S_GEN1;
			end
			S_GEN1: begin
				ctl.op  = OP_GEN_LD1;
				state_n = S_GEN2;
			end
			S_GEN2: begin
				ctl.op  = OP_GEN_LD2;
				state_n = S_RUN;
			end
			S_RUN: begin
				ctl.op = OP_GEN_RUN;
				if (sts.gen_last) begin
					state_n = S_GEND;
				end
			end
			S_GEND: begin
				ctl.op  = OP_GEN_END;
				state_n = S_RESP;
			end
			S_RESP: begin
				ctl.op  = OP_RESULT;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_n;
			busy_q  <= (state_n != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

>>> rtl/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// Life grid generation step
// Bounded B3/S23 grid with clear, cell write, cell read and advance commands.
// ----------------------------------------------------------------------------
// A command transaction is taken at a rising edge with start high and busy
// low; cmd, cell_col, cell_row and cell_value are sampled at that edge. Each
// command returns one result: done is high for exactly one cycle, with
// cell_alive and stable valid in that cycle. The receiver cannot hold it off.
// Busy falls in the done cycle, so the next command may be taken at the edge
// that ends it. The advance time is set by the sweep, which visits one cell
// per clock through a three-row window, fetching one grid row ahead per row
// on the single read port of the row-wide grid memory.
// After reset the block runs a clearing pass over both buffers, one row per
// cycle, holding busy high.
// ----------------------------------------------------------------------------
module life_grid_generation_step import lgs_pkg::*; #(
	parameter int GRID_COLS = LGS_GRID_COLS,
	parameter int GRID_ROWS = LGS_GRID_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [5:0] cell_col,
	input  logic [5:0] cell_row,
	input  logic       cell_value,
	output logic       done,
	output logic       cell_alive,
	output logic       stable
);

	lgs_ctl_t ctl;
	lgs_sts_t sts;

	lgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.ctl    (ctl),
		.sts    (sts)
	);

	lgs_datapath #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.cell_value (cell_value),
		.done       (done),
		.cell_alive (cell_alive),
		.stable     (stable)
	);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("Accepted transaction did not raise busy.");

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("Result strobe without a transaction in progress.");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe held for more than one cycle.");
`endif

endmodule

>>> tb/life_grid_generation_step_test.sv
// ----------------------------------------------------------------------------
// Life grid generation step testbench
// Sends clear, write, read and advance command transactions to the grid block,
// first from a directed table and then as random pattern sequences with noise
// in between. Results come from an independent B3/S23 grid model or the
// directed table, and are checked against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module life_grid_generation_step_test import lgs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS              = LGS_GRID_COLS * LGS_GRID_ROWS;
	localparam int BIRTH_NEIGHBOURS   = 3;
	localparam int SURVIVE_NEIGHBOURS = 2;
	localparam int DIRECTED_ITEMS     = 25;
	localparam int RANDOM_ITEMS       = 100;
	localparam int RUN_LIMIT          = 3_000_000;

	typedef struct packed {
		logic alive;
		logic stbl;
	} grid_result_t;

	typedef struct packed {
		lgs_cmd_code_t op;
		logic [5:0]    col;
		logic [5:0]    row;
		logic          val;
		logic          typed;
		logic          alive;
		logic          stbl;
	} stim_row_t;

	logic          clk        = 1'b0;
	logic          arst_n     = 1'b0;
	logic          start      = 1'b0;
	lgs_cmd_code_t cmd        = CMD_CLEAR;
	logic [5:0]    cell_col   = '0;
	logic [5:0]    cell_row   = '0;
	logic          cell_value = 1'b0;
	wire           busy;
	wire           done;
	wire           cell_alive;
	wire           stable;

	bit           board [2][CELLS];
	bit           cur_buf;
	bit           still_flag;
	grid_result_t pending_results [$];

	int cmd_count [4];
	int sent_total;
	int burst_left;
	int checked_results;
	int stable_seen;
	int err_count;
	int cycle_count;

	// Block at the far corner, blinker on the left edge.
	stim_row_t directed_rows [DIRECTED_ITEMS] = '{
		'{CMD_READ,    6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b0},
		'{CMD_ADVANCE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
		'{CMD_WRITE,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
		'{CMD_WRITE,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
		'{CMD_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b1, 1'b1},
		'{CMD_READ,    6'd63, 6'd63, 1'b1, 1'b1, 1'b1, 1'b1},
		'{CMD_WRITE,   6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b1},
		'{CMD_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b1},
		'{CMD_ADVANCE, 6'd21, 6'd42, 1'b0, 1'b1, 1'b0, 1'b0},
		'{CMD_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
		'{CMD_WRITE,   6'd62, 6'd62, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_WRITE,   6'd63, 6'd62, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_WRITE,   6'd62, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_WRITE,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_ADVANCE, 6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
		'{CMD_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b1, 1'b1},
		'{CMD_CLEAR,   6'd5,  6'd7,  1'b1, 1'b1, 1'b0, 1'b1},
		'{CMD_READ,    6'd62, 6'd62, 1'b0, 1'b1, 1'b0, 1'b1},
		'{CMD_WRITE,   6'd0,  6'd10, 1'b1, 1'b1, 1'b0, 1'b1},
		'{CMD_WRITE,   6'd0,  6'd11, 1'b1, 1'b1, 1'b0, 1'b1},
		'{CMD_WRITE,   6'd0,  6'd12, 1'b1, 1'b1, 1'b0, 1'b1},
		'{CMD_ADVANCE, 6'd42, 6'd21, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_READ,    6'd1,  6'd11, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_READ,    6'd0,  6'd10, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	life_grid_generation_step dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.cell_value (cell_value),
		.done       (done),
		.cell_alive (cell_alive),
		.stable     (stable)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int live_neighbours(bit b, int c, int r);
		int n;
		int nc;
		int nr;
		n = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				nc = c + dc;
				nr = r + dr;
				if ((dc != 0 || dr != 0) && nc >= 0 && nc < LGS_GRID_COLS &&
						nr >= 0 && nr < LGS_GRID_ROWS) begin
					n += board[b][nr * LGS_GRID_COLS + nc];
				end
			end
		end
		return n;
	endfunction

	function automatic grid_result_t apply_grid_cmd(lgs_cmd_code_t op, logic [5:0] c,
			logic [5:0] r, logic v);
		grid_result_t res;
		bit           on_grid;
		bit           same;
		bit           nv;
		bit           nxt;
		int           k;
		int           n;
		res     = '0;
		on_grid = (int'(c) < LGS_GRID_COLS) && (int'(r) < LGS_GRID_ROWS);
		k       = int'(r) * LGS_GRID_COLS + int'(c);
		case (op)
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					board[0][i] = 1'b0;
					board[1][i] = 1'b0;
				end
			end
			CMD_WRITE: begin
				if (on_grid) begin
					board[cur_buf][k] = v;
				end
			end
			CMD_READ: begin
				if (on_grid) begin
					res.alive = board[cur_buf][k];
				end
			end
			default: begin
				same = 1'b1;
				nxt  = ~cur_buf;
				for (int rr = 0; rr < LGS_GRID_ROWS; rr++) begin
					for (int cc = 0; cc < LGS_GRID_COLS; cc++) begin
						k  = rr * LGS_GRID_COLS + cc;
						n  = live_neighbours(cur_buf, cc, rr);
						nv = (n == BIRTH_NEIGHBOURS) ||
							(board[cur_buf][k] && n == SURVIVE_NEIGHBOURS);
						board[nxt][k] = nv;
						if (nv != board[cur_buf][k]) begin
							same = 1'b0;
						end
					end
				end
				cur_buf    = nxt;
				still_flag = same;
			end
		endcase
		res.stbl = still_flag;
		return res;
	endfunction

	function automatic int edge_biased_base();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 60;
			default: return $urandom_range(1, 59);
		endcase
	endfunction

	function automatic logic [5:0] near_cell(int base);
		int p;
		p = base - 1 + $urandom_range(0, 5);
		if (p < 0) begin
			p = 0;
		end
		if (p > 63) begin
			p = 63;
		end
		return 6'(p);
	endfunction

	task automatic send_cmd(lgs_cmd_code_t op, logic [5:0] c, logic [5:0] r, logic v,
			bit typed, grid_result_t typed_res);
		grid_result_t res;
		int           gap;
		start      <= 1'b1;
		cmd        <= op;
		cell_col   <= c;
		cell_row   <= r;
		cell_value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		res = apply_grid_cmd(op, c, r, v);
		pending_results.push_back(typed ? typed_res : res);
		cmd_count[op]++;
		sent_total++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	always @(posedge clk) begin
		grid_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: cell_alive %0b stable %0b", cell_alive, stable);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				checked_results++;
				if (cell_alive !== want.alive) begin
					$error("cell_alive mismatch: expected %0b, actual %0b", want.alive, cell_alive);
					err_count++;
				end
				if (stable !== want.stbl) begin
					$error("stable mismatch: expected %0b, actual %0b", want.stbl, stable);
					err_count++;
				end
				if (want.stbl) begin
					stable_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("life_grid_generation_step test failed");
			$finish;
		end
	end

	initial begin
		int base_c;
		int base_r;
		int cells;
		int gens;
		burst_left = $urandom_range(0, 12);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_cmd(directed_rows[i].op, directed_rows[i].col, directed_rows[i].row,
				directed_rows[i].val, directed_rows[i].typed,
				{directed_rows[i].alive, directed_rows[i].stbl});
		end

		while (sent_total < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) == 0) begin
				send_cmd(lgs_cmd_code_t'($urandom_range(0, 3)), 6'($urandom), 6'($urandom),
					1'($urandom), 1'b0, '0);
			end else begin
				base_c = edge_biased_base();
				base_r = edge_biased_base();
				if ($urandom_range(0, 1) == 0) begin
					send_cmd(CMD_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom), 1'b0, '0);
				end
				if ($urandom_range(0, 3) == 0) begin
					for (int i = 0; i < 4; i++) begin
						send_cmd(CMD_WRITE, 6'(base_c + i % 2), 6'(base_r + i / 2), 1'b1,
							1'b0, '0);
					end
				end else begin
					cells = $urandom_range(3, 8);
					repeat (cells) begin
						send_cmd(CMD_WRITE, 6'(base_c + $urandom_range(0, 3)),
							6'(base_r + $urandom_range(0, 3)), $urandom_range(0, 5) != 0,
							1'b0, '0);
					end
				end
				gens = $urandom_range(1, 3);
				repeat (gens) begin
					send_cmd(CMD_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom), 1'b0, '0);
					repeat ($urandom_range(2, 4)) begin
						send_cmd(CMD_READ, near_cell(base_c), near_cell(base_r),
							1'($urandom), 1'b0, '0);
					end
				end
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("Sent %0d clear, %0d write, %0d read and %0d advance transactions.",
			cmd_count[CMD_CLEAR], cmd_count[CMD_WRITE], cmd_count[CMD_READ],
			cmd_count[CMD_ADVANCE]);
		$display("Checked %0d results, %0d of them reporting a stable grid.",
			checked_results, stable_seen);
		if (err_count == 0) begin
			$display("life_grid_generation_step test passed");
		end else begin
			$display("life_grid_generation_step test failed");
		end
		$finish;
	end

endmodule
